// ===== rtl/geohash_encoder_assert.svh =====
// Assertion macros for the geohash encoder. Both expect clk and rst in scope.
`ifndef GEOHASH_ENCODER_ASSERT_SVH
`define GEOHASH_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define GH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GH_ASSERT_NOW(lbl, ante, cons, msg)
`define GH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/gh_pkg.sv =====
`timescale 1ns / 1ps
package gh_pkg;

  localparam int GH_MAX_CHARS     = 12;
  localparam int GH_FRACTION_BITS = 32;
  localparam int GH_COORD_W       = 41;
  localparam int GH_COUNT_W       = 4;
  localparam int GH_CHAR_W        = 7;
  localparam int GH_SYM_W         = 5;
  localparam int GH_LON_DEG       = 180;
  localparam int GH_LAT_DEG       = 90;
  localparam logic [GH_COUNT_W-1:0] GH_COUNT_RESET = 4'd12;

  localparam logic [255:0] GH_ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";

  // Control that travels with an item along the row of cells.
  typedef struct packed {
    logic valid;
    logic inv;
  } gh_ctrl_t;

  // The first character sits in the top byte of the packed string.
  function automatic logic [GH_CHAR_W-1:0] gh_char(input logic [GH_SYM_W-1:0] sym);
    logic [7:0] c;
    c = GH_ALPHABET[{~sym, 3'b000} +: 8];
    return c[GH_CHAR_W-1:0];
  endfunction

endpackage

// ===== rtl/geohash_encoder.sv =====
`timescale 1ns / 1ps
// The first character of an item appears once it has passed every cell of the row and the
// serializer's register. An item gives n characters, one per cycle while char_ready is high,
// or one character when flagged invalid; the serializer at the end of the row sets this.
// Reset (synchronous, rst high) clears all valid bits and sets char_count to 12;
// no clearing pass follows, and an item is accepted in the next cycle.
module geohash_encoder #(
  parameter int MAX_CHARS     = gh_pkg::GH_MAX_CHARS,
  parameter int FRACTION_BITS = gh_pkg::GH_FRACTION_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [gh_pkg::GH_COUNT_W-1:0]        cfg_wr_data,
  input  logic                                 coord_valid,
  output logic                                 coord_ready,
  input  logic signed [gh_pkg::GH_COORD_W-1:0] lat_fixed,
  input  logic signed [gh_pkg::GH_COORD_W-1:0] lon_fixed,
  output logic                                 char_valid,
  input  logic                                 char_ready,
  output logic [gh_pkg::GH_CHAR_W-1:0]         code_char,
  output logic                                 last_char,
  output logic                                 invalid
);
  import gh_pkg::*;

  `include "geohash_encoder_assert.svh"

  localparam int NBITS = GH_SYM_W * MAX_CHARS;
  localparam int DW    = FRACTION_BITS + 9;
  localparam int CW    = ((GH_COORD_W > FRACTION_BITS + 10) ? GH_COORD_W
                                                            : FRACTION_BITS + 10) + 1;

  localparam logic signed [CW-1:0] LON_MAX = CW'(64'(GH_LON_DEG) << FRACTION_BITS);
  localparam logic signed [CW-1:0] LAT_MAX = CW'(64'(GH_LAT_DEG) << FRACTION_BITS);
  localparam logic signed [CW-1:0] LON_MIN = -LON_MAX;
  localparam logic signed [CW-1:0] LAT_MIN = -LAT_MAX;
  localparam logic [DW-1:0] LON_SPAN = DW'(64'(2 * GH_LON_DEG) << FRACTION_BITS);
  localparam logic [DW-1:0] LAT_SPAN = DW'(64'(2 * GH_LAT_DEG) << FRACTION_BITS);

  logic [GH_COUNT_W-1:0] char_count;
  logic signed [CW-1:0]  lat_ext;
  logic signed [CW-1:0]  lon_ext;
  logic signed [CW-1:0]  lat_off;
  logic signed [CW-1:0]  lon_off;
  logic                  coord_inv;
  logic                  adv;
  logic                  take;

  gh_ctrl_t         ctrl  [0:NBITS];
  logic [DW-1:0]    d_lon [0:NBITS];
  logic [DW-1:0]    w_lon [0:NBITS];
  logic [DW-1:0]    d_lat [0:NBITS];
  logic [DW-1:0]    w_lat [0:NBITS];
  logic [NBITS-1:0] code  [0:NBITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= GH_COUNT_RESET;
    end else if (cfg_wr_en) begin
      char_count <= cfg_wr_data;
    end
  end

  assign lat_ext   = CW'(lat_fixed);
  assign lon_ext   = CW'(lon_fixed);
  assign lat_off   = lat_ext + LAT_MAX;
  assign lon_off   = lon_ext + LON_MAX;
  assign coord_inv = (lat_ext < LAT_MIN) || (lat_ext > LAT_MAX) ||
                     (lon_ext < LON_MIN) || (lon_ext > LON_MAX);

  // The whole row moves together; it stands still only while a finished item
  // waits at its end for the serializer.
  assign adv         = !ctrl[NBITS].valid || take;
  assign coord_ready = adv;

  assign ctrl[0]  = '{valid: coord_valid, inv: coord_inv};
  assign d_lon[0] = DW'(lon_off);
  assign w_lon[0] = LON_SPAN;
  assign d_lat[0] = DW'(lat_off);
  assign w_lat[0] = LAT_SPAN;
  assign code[0]  = '0;

  for (genvar i = 0; i < NBITS; i++) begin : g_cell
    gh_cell #(
      .DW    (DW),
      .NBITS (NBITS),
      .POS   (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .ctrl_in   (ctrl[i]),
      .d_lon_in  (d_lon[i]),
      .w_lon_in  (w_lon[i]),
      .d_lat_in  (d_lat[i]),
      .w_lat_in  (w_lat[i]),
      .code_in   (code[i]),
      .ctrl_out  (ctrl[i+1]),
      .d_lon_out (d_lon[i+1]),
      .w_lon_out (w_lon[i+1]),
      .d_lat_out (d_lat[i+1]),
      .w_lat_out (w_lat[i+1]),
      .code_out  (code[i+1])
    );
  end

  gh_serializer #(
    .MAX_CHARS (MAX_CHARS),
    .NBITS     (NBITS)
  ) u_serializer (
    .clk        (clk),
    .rst        (rst),
    .end_ctrl   (ctrl[NBITS]),
    .end_code   (code[NBITS]),
    .char_count (char_count),
    .take       (take),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .code_char  (code_char),
    .last_char  (last_char),
    .invalid    (invalid)
  );

  // A rejected pair gives exactly one result.
  `GH_ASSERT_NOW(a_inv_single, char_valid && invalid, last_char, "invalid item not last")
  // A finished item at the end of the row is never dropped.
  `GH_ASSERT_NEXT(a_end_held, ctrl[NBITS].valid && !take, ctrl[NBITS].valid,
                  "finished item lost while stalled")
  // With nothing waiting, the output goes idle after the last character.
  `GH_ASSERT_NEXT(a_idle_after_last,
                  char_valid && char_ready && last_char && !ctrl[NBITS].valid,
                  !char_valid, "result invented after last character")

endmodule

// ===== rtl/gh_cell.sv =====
`timescale 1ns / 1ps
module gh_cell #(
  parameter int DW    = 41,
  parameter int NBITS = 60,
  parameter int POS   = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  gh_pkg::gh_ctrl_t   ctrl_in,
  input  logic [DW-1:0]      d_lon_in,
  input  logic [DW-1:0]      w_lon_in,
  input  logic [DW-1:0]      d_lat_in,
  input  logic [DW-1:0]      w_lat_in,
  input  logic [NBITS-1:0]   code_in,
  output gh_pkg::gh_ctrl_t   ctrl_out,
  output logic [DW-1:0]      d_lon_out,
  output logic [DW-1:0]      w_lon_out,
  output logic [DW-1:0]      d_lat_out,
  output logic [DW-1:0]      w_lat_out,
  output logic [NBITS-1:0]   code_out
);
  import gh_pkg::*;

  // Even bit positions bisect longitude, odd ones latitude.
  localparam bit IS_LAT = (POS % 2) == 1;

  logic             valid_q;
  logic             inv_q;
  logic [DW-1:0]    d;
  logic [DW-1:0]    w;
  logic [DW-1:0]    half;
  logic [DW-1:0]    d_next;
  logic [DW-1:0]    w_next;
  logic             up;
  logic [NBITS-1:0] code_next;

  // The interval is kept as an offset of the coordinate above the low bound
  // and a width, so one compare and two subtracts make a step.
  assign d      = IS_LAT ? d_lat_in : d_lon_in;
  assign w      = IS_LAT ? w_lat_in : w_lon_in;
  assign half   = w >> 1;
  assign up     = d > half;
  assign d_next = up ? d - half : d;
  assign w_next = up ? w - half : half;

  always_comb begin
    code_next = code_in;
    code_next[NBITS-1-POS] = up;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= ctrl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv_q     <= ctrl_in.inv;
      d_lon_out <= IS_LAT ? d_lon_in : d_next;
      w_lon_out <= IS_LAT ? w_lon_in : w_next;
      d_lat_out <= IS_LAT ? d_next : d_lat_in;
      w_lat_out <= IS_LAT ? w_next : w_lat_in;
      code_out  <= code_next;
    end
  end

  assign ctrl_out = '{valid: valid_q, inv: inv_q};

endmodule

// ===== rtl/gh_serializer.sv =====
`timescale 1ns / 1ps
module gh_serializer #(
  parameter int MAX_CHARS = 12,
  parameter int NBITS     = 60
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gh_pkg::gh_ctrl_t              end_ctrl,
  input  logic [NBITS-1:0]              end_code,
  input  logic [gh_pkg::GH_COUNT_W-1:0] char_count,
  output logic                          take,
  output logic                          char_valid,
  input  logic                          char_ready,
  output logic [gh_pkg::GH_CHAR_W-1:0]  code_char,
  output logic                          last_char,
  output logic                          invalid
);
  import gh_pkg::*;

  localparam logic [GH_COUNT_W-1:0] MAX_N = GH_COUNT_W'(MAX_CHARS);

  logic                  busy;
  logic                  inv;
  logic [GH_COUNT_W-1:0] idx;
  logic [NBITS-1:0]      code_buf;
  logic [GH_COUNT_W-1:0] n_sat;

  assign n_sat     = (char_count > MAX_N) ? MAX_N : char_count;
  assign last_char = inv || (GH_COUNT_W'(idx + 1'b1) == n_sat);
  assign take      = !busy || (char_ready && last_char);

  assign char_valid = busy;
  assign invalid    = inv;
  assign code_char  = inv ? '0 : gh_char(code_buf[NBITS-1 -: GH_SYM_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (take) begin
      busy <= end_ctrl.valid;
    end
  end

  // A finished item is loaded as the previous one hands over its last character, or when idle.
  always_ff @(posedge clk) begin
    if (take) begin
      if (end_ctrl.valid) begin
        code_buf <= end_code;
        idx      <= '0;
        inv      <= end_ctrl.inv || (char_count == '0);
      end
    end else if (char_ready) begin
      code_buf <= code_buf << GH_SYM_W;
      idx      <= GH_COUNT_W'(idx + 1'b1);
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import gh_pkg::*;

  localparam longint LatLimit = longint'(GH_LAT_DEG) <<< GH_FRACTION_BITS;
  localparam longint LonLimit = longint'(GH_LON_DEG) <<< GH_FRACTION_BITS;
  localparam longint CoordMin = -(longint'(1) <<< (GH_COORD_W - 1));
  localparam longint CoordMax = (longint'(1) <<< (GH_COORD_W - 1)) - 1;
  localparam int RandomPerPhase = 44;
  localparam int Latency = 5 * GH_MAX_CHARS + 1;

  class geohash_scoreboard;
    typedef struct {
      logic [GH_CHAR_W-1:0] code;
      logic                 last;
      logic                 inv;
    } geo_char_t;

    string                alphabet = "0123456789bcdefghjkmnpqrstuvwxyz";
    geo_char_t            expected_chars[$];
    logic [GH_COUNT_W-1:0] char_count = GH_COUNT_RESET;
    int                   errors;
    int                   coords;
    int                   chars_seen;
    int                   invalid_seen;

    // Works out the geohash of one accepted pair with the current char_count.
    function void note_coord(input logic signed [GH_COORD_W-1:0] lat,
                             input logic signed [GH_COORD_W-1:0] lon);
      longint    lo[2];
      longint    hi[2];
      longint    val[2];
      longint    mid;
      int        n;
      int        axis;
      logic [GH_SYM_W-1:0] sym;
      byte       c;
      geo_char_t e;
      coords++;
      val[0] = lon;
      val[1] = lat;
      if (val[1] < -LatLimit || val[1] > LatLimit || val[0] < -LonLimit ||
          val[0] > LonLimit || char_count == 0) begin
        e.code = '0;
        e.last = 1'b1;
        e.inv  = 1'b1;
        expected_chars.push_back(e);
        return;
      end
      n = (char_count > GH_MAX_CHARS) ? GH_MAX_CHARS : int'(char_count);
      lo[0] = -LonLimit;
      hi[0] = LonLimit;
      lo[1] = -LatLimit;
      hi[1] = LatLimit;
      for (int k = 0; k < n; k++) begin
        sym = '0;
        for (int j = 0; j < GH_SYM_W; j++) begin
          // Even bits bisect longitude, odd bits latitude; a tie keeps the lower half.
          axis = (k * GH_SYM_W + j) % 2;
          mid = lo[axis] + ((hi[axis] - lo[axis]) >>> 1);
          if (val[axis] <= mid) begin
            hi[axis] = mid;
            sym = {sym[GH_SYM_W-2:0], 1'b0};
          end else begin
            lo[axis] = mid;
            sym = {sym[GH_SYM_W-2:0], 1'b1};
          end
        end
        c = alphabet[sym];
        e.code = c[GH_CHAR_W-1:0];
        e.last = (k == n - 1);
        e.inv  = 1'b0;
        expected_chars.push_back(e);
      end
    endfunction

    function void check_char(input logic [GH_CHAR_W-1:0] code, input logic last,
                             input logic inv);
      geo_char_t e;
      chars_seen++;
      if (inv === 1'b1) invalid_seen++;
      if (expected_chars.size() == 0) begin
        $error("unexpected character item: code_char %0d last_char %0b invalid %0b",
               code, last, inv);
        errors++;
        return;
      end
      e = expected_chars.pop_front();
      if (code !== e.code) begin
        $error("code_char: expected %0d, got %0d", e.code, code);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_char: expected %0b, got %0b", e.last, last);
        errors++;
      end
      if (inv !== e.inv) begin
        $error("invalid: expected %0b, got %0b", e.inv, inv);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_wr_en;
  logic [GH_COUNT_W-1:0]         cfg_wr_data;
  logic                          coord_valid;
  logic                          coord_ready;
  logic signed [GH_COORD_W-1:0]  lat_fixed;
  logic signed [GH_COORD_W-1:0]  lon_fixed;
  logic                          char_valid;
  logic                          char_ready;
  logic [GH_CHAR_W-1:0]          code_char;
  logic                          last_char;
  logic                          invalid;
  logic                          long_hold;

  geohash_scoreboard sb = new();
  int burst_left;
  int settings_used;

  geohash_encoder dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .coord_valid(coord_valid),
    .coord_ready(coord_ready),
    .lat_fixed  (lat_fixed),
    .lon_fixed  (lon_fixed),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .code_char  (code_char),
    .last_char  (last_char),
    .invalid    (invalid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly in range, with grid points to hit exact midpoints, edges and some noise.
  function automatic longint pick_coord(input longint limit);
    longint unsigned raw;
    longint unsigned span_u;
    longint          step;
    int              depth;
    int              r;
    raw = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 8) return longint'(signed'(raw[GH_COORD_W-1:0]));
    if (r < 25) begin
      depth = $urandom_range(1, 20);
      step = (2 * limit) >>> depth;
      return -limit + longint'($urandom_range(0, 1 << depth)) * step;
    end
    if (r < 33) begin
      return ($urandom_range(0, 1) ? limit : -limit) + longint'($urandom_range(0, 2)) - 1;
    end
    span_u = 2 * limit + 1;
    return longint'(raw % span_u) - limit;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(15, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_coord(input longint lat, input longint lon, input int gap);
    coord_valid <= 1'b1;
    lat_fixed   <= GH_COORD_W'(lat);
    lon_fixed   <= GH_COORD_W'(lon);
    @(posedge clk);
    while (!coord_ready) @(posedge clk);
    sb.note_coord(GH_COORD_W'(lat), GH_COORD_W'(lon));
    if (gap > 0) begin
      coord_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    coord_valid <= 1'b0;
    while (sb.expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic write_char_count(input logic [GH_COUNT_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.char_count = value;
    settings_used++;
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++)
      send_coord(pick_coord(LatLimit), pick_coord(LonLimit), pick_gap());
  endtask

  initial begin : stimulus
    logic [GH_COUNT_W-1:0] phase_counts[7];
    phase_counts = '{4'd1, 4'd0, 4'd15, 4'd13, 4'd5, 4'd2, 4'd12};
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    coord_valid <= 1'b0;
    lat_fixed   <= '0;
    lon_fixed   <= '0;
    long_hold   <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    settings_used = 1;

    // Corners, exact bounds, one step outside them, midpoints and field extremes.
    send_coord(0, 0, 0);
    send_coord(LatLimit, LonLimit, 0);
    send_coord(-LatLimit, -LonLimit, 1);
    send_coord(LatLimit, -LonLimit, 0);
    send_coord(-LatLimit, LonLimit, 0);
    send_coord(LatLimit + 1, 0, 0);
    send_coord(-LatLimit - 1, 0, 2);
    send_coord(0, LonLimit + 1, 0);
    send_coord(0, -LonLimit - 1, 0);
    send_coord(CoordMin, CoordMax, 0);
    send_coord(CoordMax, CoordMin, 0);
    send_coord(CoordMin, CoordMin, 3);
    send_coord(CoordMax, CoordMax, 0);
    send_coord(LatLimit >>> 1, LonLimit >>> 1, 0);
    send_coord(-(LatLimit >>> 1), -(LonLimit >>> 1), 0);
    send_coord(1, 1, 0);
    send_coord(-1, -1, 0);
    send_coord(LatLimit >>> 7, -(LonLimit >>> 9), 1);
    send_coord(64'sh55_5555_5555, -64'sh2A_AAAA_AAAA, 0);
    send_coord(CoordMax >>> 2, CoordMin >>> 2, 0);

    // The result side now stalls for a long stretch while items keep coming.
    long_hold <= 1'b1;
    send_random(RandomPerPhase / 2);
    drain();
    send_random(RandomPerPhase - RandomPerPhase / 2);

    foreach (phase_counts[p]) begin
      write_char_count(phase_counts[p]);
      send_random(RandomPerPhase);
    end
    write_char_count(4'($urandom_range(0, 15)));
    send_random(RandomPerPhase);

    drain();
    repeat (Latency + 20) @(posedge clk);
    $display("Checked %0d coordinate pairs giving %0d characters, %0d of them invalid,",
             sb.coords, sb.chars_seen, sb.invalid_seen);
    $display("over %0d char_count settings including zero and saturating values.",
             settings_used);
    if (sb.errors == 0 && sb.expected_chars.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    int  stall_left;
    int  calm_left;
    int  r;
    bit  held;
    logic next_ready;
    stall_left = 0;
    calm_left = 0;
    held = 1'b0;
    char_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && char_valid && char_ready) sb.check_char(code_char, last_char, invalid);
      if (long_hold && !held) begin
        held = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        next_ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        next_ready = 1'b1;
        if (r < 4) begin
          calm_left = $urandom_range(50, 150);
        end else if (r >= 70 && r < 93) begin
          next_ready = 1'b0;
          stall_left = $urandom_range(0, 2);
        end else if (r >= 93) begin
          next_ready = 1'b0;
          stall_left = $urandom_range(9, 39);
        end
      end
      char_ready <= next_ready;
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
